[sv/exponential_prefix_codec_assert.svh]
// Assertion macros for the exponential prefix codec.
// Used by the top level only; no other dependencies.
`ifndef EXPONENTIAL_PREFIX_CODEC_ASSERT_SVH
`define EXPONENTIAL_PREFIX_CODEC_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent in one cycle implies consequent in the next cycle.
`define EPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Antecedent implies consequent in the same cycle.
`define EPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`else

`define EPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define EPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`endif

`endif

[sv/epc_pkg.sv]
// Shared types and constants for the exponential prefix codec.
// No dependencies; imported by epc_alu, exponential_prefix_codec and the testbench.
package epc_pkg;

    localparam int WORD_BITS = 63;
    localparam int LEN_W     = 6;
    localparam int DSZ_W     = 33;
    localparam int SCNT_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DECADE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_COUNT = 2'd2;

    // Command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Register reset values
    localparam logic [DSZ_W-1:0]  DECADE_SIZE_RST = 33'd5;
    localparam logic [LEN_W-1:0]  CODE_WIDTH_RST  = 6'd4;
    localparam logic [SCNT_W-1:0] SHORT_COUNT_RST = 32'd3;

    // Longest legal code
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [LEN_W-1:0]     len_t;

    // Result of the shared adder
    typedef struct packed {
        logic  borrow;
        word_t sum;
    } alu_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_SUB,
        ST_E_LOOP,
        ST_E_ADD1,
        ST_E_ADD2,
        ST_D_CS,
        ST_D_SHORT,
        ST_D_QA,
        ST_D_QB,
        ST_D_LOOP,
        ST_D_END,
        ST_PUSH
    } state_t;

endpackage

[sv/exponential_prefix_codec.sv]
// Exponential prefix codec: base-2 infinite Huffman encoder/decoder.
// One item is accepted on s_*; its result leaves on m_* through an output register.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata, index 0 decade_size, 1 code_width,
// 2 short_count; write only while the block is idle.
// s_tuser selects the direction (0 encode, 1 decode); s_tdata carries the operand.
// m_tdata returns the value and the code length (length 0 means too long or invalid, or a short code at code_width 1).
// One item is processed at a time by a sequencer around one shared adder and one
// barrel shifter. Encode tests for a short code (ST_E_SUB), else steps over the
// decades (ST_E_LOOP, at most 63 - code_width of them), then adds in ST_E_ADD1 and
// ST_E_ADD2; decode compares with cs (ST_D_CS), then takes a short code (ST_D_SHORT)
// or runs ST_D_QA, ST_D_QB, ST_D_LOOP and ST_D_END. ST_PUSH then moves the result
// into the output register, and the sequencer returns to idle before the next
// transaction can be accepted.
// s_tready is high only while the sequencer is idle. A finished result waits in the
// output register while the next transaction is accepted; the sequencer holds its
// next result until the receiver takes the previous one.
// Reset (aresetn low, synchronous) loads the register defaults (decade_size 5,
// code_width 4, short_count 3), clears the sequencer and drops m_tvalid.
`include "exponential_prefix_codec_assert.svh"

module exponential_prefix_codec (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [32:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] operand, [63] zero pad
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [62:0] value, [68:63] bit_length, [71:69] zero pad
);
    import epc_pkg::*;

    // Configuration registers
    logic [DSZ_W-1:0]  decade_size_reg;
    len_t              code_width_reg;
    logic [SCNT_W-1:0] short_count_reg;

    // Sequencer and datapath registers
    state_t state_reg, state_next;
    word_t  k_reg, k_next;       // message number (encode) or shifted code word
    word_t  acc_reg, acc_next;   // prefix ones (encode) or message base v (decode)
    word_t  q_reg, q_next;       // decade threshold qcs
    len_t   len_reg, len_next;
    word_t  res_val_reg, res_val_next;
    len_t   res_len_reg, res_len_next;

    // Output register
    logic   m_tvalid_reg, m_tvalid_next;
    word_t  m_val_reg, m_val_next;
    len_t   m_len_reg, m_len_next;

    // Shared units
    word_t    alu_a, alu_b;
    logic     alu_sub;
    alu_res_t alu_res;
    word_t    sh_in, sh_out;
    logic     sh_left;
    len_t     sh_amt;

    // Derived terms
    word_t cq;
    word_t w_bit;
    len_t  w_m1;
    logic  s_accept;
    logic  out_free;
    logic  push;

    assign cq       = WORD_BITS'({short_count_reg, 1'b0});
    assign w_bit    = word_t'(1) << code_width_reg;
    assign w_m1     = code_width_reg - len_t'(1);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign push     = (state_reg == ST_PUSH) & out_free;

    epc_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    // Shared barrel shifter
    always_comb begin
        sh_out = sh_left ? (sh_in << sh_amt) : (sh_in >> sh_amt);
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decade_size_reg <= DECADE_SIZE_RST;
            code_width_reg  <= CODE_WIDTH_RST;
            short_count_reg <= SHORT_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DECADE_SIZE: decade_size_reg <= cfg_wdata;
                REG_CODE_WIDTH:  code_width_reg  <= cfg_wdata[LEN_W-1:0];
                REG_SHORT_COUNT: short_count_reg <= cfg_wdata[SCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        q_reg       <= q_next;
        len_reg     <= len_next;
        res_val_reg <= res_val_next;
        res_len_reg <= res_len_next;
        m_val_reg   <= m_val_next;
        m_len_reg   <= m_len_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        q_next        = q_reg;
        len_next      = len_reg;
        res_val_next  = res_val_reg;
        res_len_next  = res_len_reg;
        m_tvalid_next = m_tvalid_reg;
        m_val_next    = m_val_reg;
        m_len_next    = m_len_reg;

        alu_a   = k_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        sh_in   = k_reg;
        sh_left = 1'b0;
        sh_amt  = '0;

        // Receiver drains the output register
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    k_next   = s_tdata[WORD_BITS-1:0];
                    acc_next = '0;
                    len_next = code_width_reg;
                    if (code_width_reg == '0 || code_width_reg >= LEN_MAX) begin
                        res_val_next = '0;
                        res_len_next = '0;
                        state_next   = ST_PUSH;
                    end else if (s_tuser == CMD_DECODE) begin
                        state_next = ST_D_CS;
                    end else begin
                        state_next = ST_E_SUB;
                    end
                end
            end

            // Encode: short code test, k - c
            ST_E_SUB: begin
                alu_a   = k_reg;
                alu_b   = WORD_BITS'(short_count_reg);
                alu_sub = 1'b1;
                if (alu_res.borrow) begin
                    res_val_next = k_reg;
                    res_len_next = w_m1;
                    state_next   = ST_PUSH;
                end else begin
                    k_next     = alu_res.sum;
                    state_next = ST_E_LOOP;
                end
            end

            // Encode: step over one decade per cycle
            ST_E_LOOP: begin
                alu_a   = k_reg;
                alu_b   = WORD_BITS'(decade_size_reg);
                alu_sub = 1'b1;
                if (alu_res.borrow) begin
                    state_next = ST_E_ADD1;
                end else if (len_reg == LEN_MAX) begin
                    res_val_next = '0;
                    res_len_next = '0;
                    state_next   = ST_PUSH;
                end else begin
                    len_next = len_reg + len_t'(1);
                    k_next   = alu_res.sum;
                    acc_next = {acc_reg[WORD_BITS-2:0], 1'b0} | w_bit;
                end
            end

            // Encode: prefix ones plus remainder
            ST_E_ADD1: begin
                alu_a      = acc_reg;
                alu_b      = k_reg;
                k_next     = alu_res.sum;
                state_next = ST_E_ADD2;
            end

            // Encode: add 2c
            ST_E_ADD2: begin
                alu_a        = k_reg;
                alu_b        = cq;
                res_val_next = alu_res.sum;
                res_len_next = len_reg;
                state_next   = ST_PUSH;
            end

            // Decode: compare with cs = cq << (63 - w)
            ST_D_CS: begin
                sh_in   = cq;
                sh_left = 1'b1;
                sh_amt  = len_t'(7'(WORD_BITS) - {1'b0, code_width_reg});
                alu_a   = k_reg;
                alu_b   = sh_out;
                alu_sub = 1'b1;
                state_next = alu_res.borrow ? ST_D_SHORT : ST_D_QA;
            end

            // Decode: short code is the top w-1 bits
            ST_D_SHORT: begin
                sh_in        = k_reg;
                sh_amt       = len_t'(7'(WORD_BITS + 1) - {1'b0, code_width_reg});
                res_val_next = sh_out;
                res_len_next = w_m1;
                state_next   = ST_PUSH;
            end

            // Decode: 2^w + cq
            ST_D_QA: begin
                alu_a      = w_bit;
                alu_b      = cq;
                q_next     = alu_res.sum;
                state_next = ST_D_QB;
            end

            // Decode: align qcs, and start v at c - 2c
            ST_D_QB: begin
                sh_in      = q_reg;
                sh_left    = 1'b1;
                sh_amt     = len_t'(7'(WORD_BITS - 1) - {1'b0, code_width_reg});
                q_next     = sh_out;
                alu_a      = '0;
                alu_b      = WORD_BITS'(short_count_reg);
                alu_sub    = 1'b1;
                acc_next   = alu_res.sum;
                state_next = ST_D_LOOP;
            end

            // Decode: one leading 1 bit per cycle
            ST_D_LOOP: begin
                alu_a = acc_reg;
                alu_b = WORD_BITS'(decade_size_reg);
                if (k_reg >= q_reg) begin
                    if (len_reg == LEN_MAX) begin
                        res_val_next = '0;
                        res_len_next = '0;
                        state_next   = ST_PUSH;
                    end else begin
                        len_next = len_reg + len_t'(1);
                        k_next   = {k_reg[WORD_BITS-2:0], 1'b0};
                        acc_next = alu_res.sum;
                    end
                end else begin
                    state_next = ST_D_END;
                end
            end

            // Decode: v plus the top w bits
            ST_D_END: begin
                sh_in        = k_reg;
                sh_amt       = len_t'(7'(WORD_BITS) - {1'b0, code_width_reg});
                alu_a        = acc_reg;
                alu_b        = sh_out;
                res_val_next = alu_res.sum;
                res_len_next = len_reg;
                state_next   = ST_PUSH;
            end

            // Hand the result to the output register
            ST_PUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_val_next    = res_val_reg;
                    m_len_next    = res_len_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_len_reg, m_val_reg};

    // Checks on the sequencer and output register
    `EPC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready)
    `EPC_ASSERT_NEXT(a_push_sets_valid, aclk, aresetn, push, m_tvalid)
    `EPC_ASSERT_NEXT(a_no_repeat, aclk, aresetn, m_tvalid && m_tready && !push, !m_tvalid)
    `EPC_ASSERT_NOW(a_push_needs_room, aclk, aresetn, m_tvalid && !m_tready, !push)

endmodule

[sv/epc_alu.sv]
// Shared add/subtract unit of the exponential prefix codec.
// Depends on epc_pkg.
module epc_alu (
    input  epc_pkg::word_t    a,
    input  epc_pkg::word_t    b,
    input  logic              sub,
    output epc_pkg::alu_res_t res
);
    import epc_pkg::*;

    logic [WORD_BITS:0] full;

    // a + b, or a + ~b + 1; borrow means a < b on a subtract
    always_comb begin
        full       = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WORD_BITS{1'b0}}, sub};
        res.sum    = full[WORD_BITS-1:0];
        res.borrow = sub & ~full[WORD_BITS];
    end

endmodule

[tb/epc_result_checker.sv]
// Result checker for the exponential prefix codec: tracks register writes, predicts
// the result of every accepted input transaction and compares it with the output stream.
// Depends on epc_pkg for widths, register indexes and command codes.
`timescale 1ns / 1ps

module epc_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [32:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] operand, [63] zero pad
    input  logic        s_tuser,   // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [62:0] value, [68:63] bit_length, [71:69] zero pad
    output int          mismatches,
    output int          pending
);
    import epc_pkg::*;

    typedef struct packed {
        word_t value;
        len_t  bit_length;
    } code_res_t;

    localparam logic [63:0] WMASK = {1'b0, {63{1'b1}}};

    // Shadow copy of the configuration registers
    logic [DSZ_W-1:0]  cfg_decade = DECADE_SIZE_RST;
    logic [LEN_W-1:0]  cfg_width  = CODE_WIDTH_RST;
    logic [SCNT_W-1:0] cfg_short  = SHORT_COUNT_RST;

    code_res_t expected_codes[$];
    int        errs    = 0;
    int        n_words = 0;

    // Message number -> right-justified codeword and its length
    function automatic code_res_t encode_number(logic [63:0] k);
        code_res_t   r;
        logic [63:0] c, d, y;
        int unsigned len;
        r   = '0;
        c   = {32'b0, cfg_short};
        d   = {31'b0, cfg_decade};
        y   = 64'd1;
        len = cfg_width;
        if (k < c) begin
            r.value      = k[62:0];
            r.bit_length = len_t'(cfg_width - 1);
            return r;
        end
        k = k - c;
        // one leading 1 bit more for every decade stepped over
        while (k >= d) begin
            len++;
            if (len > WORD_BITS)
                return '0;
            k = k - d;
            y = y << 1;
        end
        r.value      = word_t'(((y - 64'd1) << cfg_width) + (c << 1) + k);
        r.bit_length = len_t'(len);
        return r;
    endfunction

    // Left-justified word -> message number and length of the consumed prefix
    function automatic code_res_t decode_word(word_t word);
        code_res_t   r;
        logic [63:0] c, cq, cs, qcs, v, y;
        int unsigned w, len;
        r   = '0;
        w   = cfg_width;
        len = w;
        c   = {32'b0, cfg_short};
        cq  = c << 1;
        cs  = (cq << (WORD_BITS - w)) & WMASK;
        qcs = (((64'd1 << w) + cq) << (WORD_BITS - 1 - w)) & WMASK;
        v   = c - cq;
        y   = {1'b0, word};
        if (y < cs) begin
            r.value      = word_t'(y >> (WORD_BITS + 1 - w));
            r.bit_length = len_t'(w - 1);
            return r;
        end
        while (y >= qcs) begin
            len++;
            if (len > WORD_BITS)
                return '0;
            y = (y << 1) & WMASK;
            v = v + {31'b0, cfg_decade};
        end
        r.value      = word_t'(v + (y >> (WORD_BITS - w)));
        r.bit_length = len_t'(len);
        return r;
    endfunction

    function automatic code_res_t compute_code(logic cmd, word_t operand);
        if (cfg_width == 0 || cfg_width >= WORD_BITS)
            return '0;
        if (cmd == CMD_ENCODE)
            return encode_number({1'b0, operand});
        return decode_word(operand);
    endfunction

    always @(posedge aclk) begin : watch
        code_res_t got, want;
        if (!aresetn) begin
            cfg_decade = DECADE_SIZE_RST;
            cfg_width  = CODE_WIDTH_RST;
            cfg_short  = SHORT_COUNT_RST;
            expected_codes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DECADE_SIZE: cfg_decade = cfg_wdata;
                    REG_CODE_WIDTH:  cfg_width  = cfg_wdata[LEN_W-1:0];
                    REG_SHORT_COUNT: cfg_short  = cfg_wdata[SCNT_W-1:0];
                    default: ;
                endcase
            end
            // output side first: a result can never belong to an item accepted this edge
            if (m_tvalid && m_tready) begin
                got.value      = m_tdata[62:0];
                got.bit_length = m_tdata[68:63];
                if (expected_codes.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("result %0d: unexpected, value %h bit_length %0d",
                                 n_words, got.value, got.bit_length);
                end else begin
                    want = expected_codes.pop_front();
                    if (got.value !== want.value || got.bit_length !== want.bit_length) begin
                        errs++;
                        if (errs <= 10)
                            $display("result %0d: value exp %h got %h, bit_length exp %0d got %0d",
                                     n_words, want.value, got.value,
                                     want.bit_length, got.bit_length);
                    end
                end
                n_words++;
            end
            if (s_tvalid && s_tready)
                expected_codes.push_back(compute_code(s_tuser, s_tdata[62:0]));
        end
        mismatches <= errs;
        pending    <= expected_codes.size();
    end

endmodule

[tb/exponential_prefix_codec_tb.sv]
// Top of the exponential prefix codec testbench: clock, reset, stimulus and verdict.
// Instantiates the codec and epc_result_checker, which predicts and compares results.
// Depends on epc_pkg.
`timescale 1ns / 1ps

module exponential_prefix_codec_tb;
    import epc_pkg::*;

    localparam int          IDLE_LIMIT = 2000;
    localparam int          N_PHASES   = 20;
    localparam int          PHASE_ITEMS = 40;
    localparam logic [63:0] WMASK      = {1'b0, {63{1'b1}}};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [32:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;

    int mismatches;
    int pending;

    // Register values currently loaded, used to aim the operands
    logic [DSZ_W-1:0]  cur_dsz = DECADE_SIZE_RST;
    logic [LEN_W-1:0]  cur_w   = CODE_WIDTH_RST;
    logic [SCNT_W-1:0] cur_sc  = SHORT_COUNT_RST;

    int burst_left  = 8;
    int n_enc       = 0;
    int n_dec       = 0;
    int n_settings  = 0;
    int idle_cycles = 0;
    int calm_left   = 0;
    int stall_left  = 0;

    exponential_prefix_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    epc_result_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: mostly random stalls, occasional long stalls and calm stretches
    always @(posedge aclk) begin
        if (calm_left > 0) begin
            calm_left--;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0:       calm_left  = $urandom_range(50, 300);
                1, 2:    stall_left = $urandom_range(1, 30);
                default: ;
            endcase
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog: too long without any transaction means the block hung
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one item; between bursts the sender idles for a random gap
    task automatic put_item(input logic cmd, input word_t op);
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_ENCODE)
            n_enc++;
        else
            n_dec++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold off until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Load all three registers on consecutive cycles while the block is idle
    task automatic apply_setting(input logic [DSZ_W-1:0] dsz, input logic [LEN_W-1:0] w,
                                 input logic [SCNT_W-1:0] sc);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DECADE_SIZE;
        cfg_wdata <= dsz;
        @(posedge aclk);
        cfg_addr  <= REG_CODE_WIDTH;
        cfg_wdata <= {27'b0, w};
        @(posedge aclk);
        cfg_addr  <= REG_SHORT_COUNT;
        cfg_wdata <= {1'b0, sc};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_dsz = dsz;
        cur_w   = w;
        cur_sc  = sc;
        n_settings++;
    endtask

    // Message number: short codes, codes up to 64 - w decades deep, or anything
    function automatic word_t pick_message();
        logic [63:0] k, c, d, r;
        int unsigned j;
        c = {32'b0, cur_sc};
        d = {31'b0, cur_dsz};
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       k = r;
            1, 2:    k = (c == 0) ? 64'd0 : r % c;
            default: begin
                j = $urandom_range(0, 64 - cur_w);
                k = c + d * j + ((d == 0) ? 64'd0 : r % d);
            end
        endcase
        return k[62:0];
    endfunction

    // Decoder word: a run of leading ones then a zero and random tail, small words, or noise
    function automatic word_t pick_codeword();
        logic [63:0] r, y;
        int unsigned q;
        r = {$urandom, $urandom} & WMASK;
        case ($urandom_range(0, 9))
            0:       y = r;
            1, 2:    y = r >> $urandom_range(0, 62);
            default: begin
                q = $urandom_range(0, 64 - cur_w);
                y = (~(WMASK >> q) & WMASK) | (r & (WMASK >> (q + 1)));
            end
        endcase
        return y[62:0];
    endfunction

    initial begin : stimulus
        logic [DSZ_W-1:0]  dsz_n;
        logic [LEN_W-1:0]  w_n;
        logic [SCNT_W-1:0] sc_n;
        logic [63:0]       half;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers (n 5, w 4, c 3)
        put_item(CMD_ENCODE, '0);
        put_item(CMD_ENCODE, 63'd2);                     // last short code
        put_item(CMD_ENCODE, 63'd3);                     // first code of the first decade
        put_item(CMD_ENCODE, 63'd8);                     // first code of the second decade
        put_item(CMD_ENCODE, {63{1'b1}});                // overlong
        put_item(CMD_DECODE, '0);
        put_item(CMD_DECODE, {63{1'b1}});                // overlong prefix
        put_item(CMD_DECODE, {3'b010, 60'd0});           // short code
        put_item(CMD_DECODE, {3'b011, 60'd0});           // right at the short code bound
        put_item(CMD_DECODE, {5'b11010, 58'd0});
        // bad code widths, both directions
        apply_setting(33'd5, 6'd0, 32'd3);
        put_item(CMD_ENCODE, 63'd5);
        put_item(CMD_DECODE, 63'd5);
        apply_setting(33'd5, 6'd63, 32'd3);
        put_item(CMD_ENCODE, 63'd1);
        put_item(CMD_DECODE, {63{1'b1}});
        // code width 1: the short code reads as length zero, the decode runs to the length bound
        apply_setting(33'd1, 6'd1, 32'd1);
        put_item(CMD_ENCODE, '0);
        put_item(CMD_DECODE, '0);
        // zero decade size runs into the length bound
        apply_setting(33'd0, 6'd4, 32'd3);
        put_item(CMD_ENCODE, 63'd10);
        // widest legal code width with the largest register values
        apply_setting({DSZ_W{1'b1}}, 6'd62, {SCNT_W{1'b1}});
        put_item(CMD_ENCODE, {63{1'b1}});
        put_item(CMD_DECODE, {63{1'b1}});

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:  apply_setting(DECADE_SIZE_RST, CODE_WIDTH_RST, SHORT_COUNT_RST);
                1:  apply_setting(33'd1, 6'd1, 32'd0);
                2:  apply_setting(33'h1_0000_0000, 6'd33, 32'd0);
                3:  apply_setting(33'd1, 6'd33, 32'hFFFF_FFFF);
                4:  apply_setting(33'h1_FFFF_FFFF, 6'd62, 32'hFFFF_FFFF);
                5:  apply_setting(33'd0, 6'd8, 32'd100);
                6:  apply_setting(33'd5, 6'd0, 32'd3);
                7:  apply_setting(33'd5, 6'd63, 32'd3);
                8:  apply_setting(33'd1, 6'd2, 32'd1);
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        dsz_n = {1'($urandom_range(0, 1)), $urandom};
                        w_n   = 6'($urandom_range(0, 63));
                        sc_n  = $urandom;
                    end else begin
                        // consistent set: c = 2^(w-1) - n
                        w_n   = 6'($urandom_range(2, 33));
                        half  = 64'd1 << (w_n - 1);
                        dsz_n = DSZ_W'(64'd1 + ({$urandom, $urandom} % half));
                        sc_n  = SCNT_W'(half - {31'b0, dsz_n});
                    end
                    apply_setting(dsz_n, w_n, sc_n);
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 1) == 0)
                    put_item(CMD_ENCODE, pick_message());
                else
                    put_item(CMD_DECODE, pick_codeword());
            end
        end

        // Drain and give late or extra results a chance to show up
        wait_drained();
        repeat (100) @(posedge aclk);

        $display("Ran %0d encode and %0d decode transactions over %0d register settings,",
                 n_enc, n_dec, n_settings);
        $display("with bursty input, receiver stalls and %0d mismatches.", mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/epc_pkg.sv
sv/epc_alu.sv
sv/exponential_prefix_codec.sv
tb/epc_result_checker.sv
tb/exponential_prefix_codec_tb.sv
